// ===== hdl/bfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

  localparam int TOT_W   = 13;
  localparam int LIM_W   = 6;
  localparam int BLK_W   = 12;
  localparam int CFG_W   = 13;
  localparam int CFG_I_W = 1;

  localparam logic [TOT_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [LIM_W-1:0] LIMIT_RST = 6'd60;

  typedef enum logic [CFG_I_W-1:0] {
    REG_TOTAL = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_REPLENISH = 1'b0,
    CMD_FREE      = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic             command;
    logic [BLK_W-1:0] blk_num;
    logic             cache_empty;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_ref;
    logic             ref_valid;
    logic             last;
    logic             exhausted;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic acc_free;
    logic acc_scan;
    logic acc_none;
    logic acc_exh;
    logic div_mul;
    logic div_fix;
    logic rd_cur;
    logic set_bit;
    logic find_step;
    logic emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic go_free;
    logic go_scan;
    logic go_none;
    logic go_exh;
    logic find_end;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bitmap_free_block_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// next-fit free block allocator over a bitmap held in a single-port-write ram
// input: start with in_data is taken when busy is low; busy stays high while
//   the item is worked on
// free command: busy through index split, read and set bit; no result
// replenish with cache_empty low, or a free of a block beyond the total:
//   taken and dropped at once
// replenish: setup (index split, read), then the scan loop visits one bitmap
//   word per cycle while it finds no free block, and stays on a word while
//   it hands out blocks from it; the final beat is sent from the done state
//   after the loop ends
// results: out_valid marks each beat for one cycle; there is no back-pressure,
//   the receiver must take every beat; the final beat carries last
// configuration: cfg_we with cfg_index and cfg_data; the user must write
//   only while the block is idle, which the block itself does not enforce
// reset: synchronous, rst_n low; afterwards busy stays high while the bitmap
//   is swept to all zeros, one word a cycle

module bitmap_free_block_scanner
  import bfs_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096,
  parameter int CACHE_REFS = 60,
  parameter int WORD_BITS  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  output out_item_t               out_data,
  input  wire logic               cfg_we,
  input  wire logic [CFG_I_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bfs_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CACHE_REFS (CACHE_REFS),
    .WORD_BITS  (WORD_BITS),
    .MAP_WORDS  (MAP_WORDS),
    .AW         (AW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  bfs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/bfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/bfs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfs_ctrl
  import bfs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_FDIV1 = 11'b000_0000_0100,
    S_FDIV2 = 11'b000_0000_1000,
    S_FRD   = 11'b000_0001_0000,
    S_FSET  = 11'b000_0010_0000,
    S_SDIV1 = 11'b000_0100_0000,
    S_SDIV2 = 11'b000_1000_0000,
    S_SRD   = 11'b001_0000_0000,
    S_FIND  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (sts.go_free) begin
            cmd.acc_free = 1'b1;
            state_nxt    = S_FDIV1;
          end else if (sts.go_scan) begin
            cmd.acc_scan = 1'b1;
            state_nxt    = S_SDIV1;
          end else if (sts.go_none) begin
            cmd.acc_none = 1'b1;
            state_nxt    = S_DONE;
          end else if (sts.go_exh) begin
            cmd.acc_exh = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end
      S_FDIV1: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_FDIV2;
      end
      S_FDIV2: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_FRD;
      end
      S_FRD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_FSET;
      end
      S_FSET: begin
        cmd.set_bit = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SDIV1: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_SDIV2;
      end
      S_SDIV2: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_SRD;
      end
      S_SRD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_FIND;
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.find_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/bfs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfs_datapath
  import bfs_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096,
  parameter int CACHE_REFS = 60,
  parameter int WORD_BITS  = 32,
  parameter int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
  parameter int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_I_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_waddr,
  output logic [WORD_BITS-1:0]      ram_wdata,
  output logic                      ram_re,
  output logic [AW-1:0]             ram_raddr,
  input  wire logic [WORD_BITS-1:0] ram_rdata,
  output logic                      out_valid,
  output out_item_t                 out_data
);

  localparam int W     = WORD_BITS;
  localparam int PW    = $clog2(WORD_BITS);
  localparam int BOW   = $clog2(WORD_BITS + 1);
  localparam int MW    = $clog2((1 << TOT_W) + WORD_BITS);
  localparam int MAXC  = (MAX_BLOCKS < (1 << TOT_W) - 1) ? MAX_BLOCKS : (1 << TOT_W) - 1;
  localparam int LIMC  = (CACHE_REFS < (1 << LIM_W) - 1) ? CACHE_REFS : (1 << LIM_W) - 1;
  localparam int SH    = BLK_W;
  localparam int RECIP = (1 << SH) / WORD_BITS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PRW   = BLK_W + RW;

  localparam logic [TOT_W-1:0] MAXC_V  = TOT_W'(MAXC);
  localparam logic [LIM_W-1:0] LIMC_V  = LIM_W'(LIMC);
  localparam logic [RW-1:0]    RECIP_V = RW'(RECIP);
  localparam logic [BOW-1:0]   W_V     = BOW'(WORD_BITS);
  localparam logic [AW-1:0]    LAST_WA = AW'(MAP_WORDS - 1);

  // control state
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [LIM_W-1:0] limit_r, limit_nxt;
  logic [BLK_W-1:0] ptr_r, ptr_nxt;
  logic             null_r, null_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic             out_valid_r, out_valid_nxt;

  // scan and payload state
  logic [BLK_W-1:0] x_r, x_nxt;
  logic [PRW-1:0]   prod_r, prod_nxt;
  logic [TOT_W-1:0] wb_r, wb_nxt;
  logic [BOW-1:0]   bo_r, bo_nxt;
  logic [W-1:0]     word_r, word_nxt;
  logic             use_rd_r, use_rd_nxt;
  logic [MW-1:0]    miss_r, miss_nxt;
  logic [LIM_W-1:0] cnt_r, cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [BLK_W-1:0] pend_ref_r, pend_ref_nxt;
  logic             exh_r, exh_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [TOT_W-1:0]   tot;
  logic [LIM_W-1:0]   lim;
  logic [BLK_W-1:0]   start_idx;
  logic               block_ok;
  logic               is_repl;

  // word and bit split of the stored index
  logic [RW-1:0]      q0;
  logic [RW+BOW-1:0]  qw;
  logic [BLK_W-1:0]   r0;
  logic               div_fix;
  logic [RW-1:0]      q_fin;
  logic [BLK_W-1:0]   r_fin;

  // one word of the scan
  logic [W-1:0]       src;
  logic [TOT_W-1:0]   rem;
  logic [BOW-1:0]     endp;
  logic [W-1:0]       win;
  logic [W-1:0]       m;
  logic [W-1:0]       lowbit;
  logic [PW-1:0]      p;
  logic               hit;
  logic [LIM_W:0]     cnt_inc;
  logic               lim_hit;
  logic [TOT_W:0]     np;
  logic [MW-1:0]      miss_add;
  logic               exh_hit;
  logic               wrap_w;
  logic [AW-1:0]      next_wa;
  logic [TOT_W-1:0]   next_wb;
  logic [TOT_W-1:0]   found_idx;

  assign tot       = (total_r > MAXC_V) ? MAXC_V : total_r;
  assign lim       = (limit_r > LIMC_V) ? LIMC_V : limit_r;
  assign start_idx = (null_r || ({1'b0, ptr_r} >= tot)) ? '0 : ptr_r;
  assign block_ok  = ({1'b0, in_data.blk_num} < tot);
  assign is_repl   = (in_data.command == CMD_REPLENISH) && in_data.cache_empty;

  assign sts.clr_last = (wa_r == LAST_WA);
  assign sts.go_free  = (in_data.command == CMD_FREE) && block_ok;
  assign sts.go_none  = is_repl && (lim == '0);
  assign sts.go_exh   = is_repl && (lim != '0) && (tot == '0);
  assign sts.go_scan  = is_repl && (lim != '0) && (tot != '0);
  assign sts.find_end = cmd.find_step && ((hit && lim_hit) || exh_hit);

  assign q0      = prod_r[PRW-1:SH];
  assign qw      = {{BOW{1'b0}}, q0} * {{RW{1'b0}}, W_V};
  assign r0      = x_r - qw[BLK_W-1:0];
  assign div_fix = (r0 >= BLK_W'(W));
  assign q_fin   = div_fix ? q0 + RW'(1) : q0;
  assign r_fin   = div_fix ? r0 - BLK_W'(W) : r0;

  assign src  = use_rd_r ? ram_rdata : word_r;
  assign rem  = tot - wb_r;
  assign endp = (rem >= TOT_W'(W)) ? W_V : rem[BOW-1:0];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      win[i] = (BOW'(i) >= bo_r) && (BOW'(i) < endp);
    end
  end

  assign m      = src & win;
  assign lowbit = m & (~m + W'(1));
  assign hit    = |m;

  always_comb begin
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (lowbit[i]) begin
        p = p | PW'(i);
      end
    end
  end

  assign cnt_inc   = {1'b0, cnt_r} + (LIM_W + 1)'(1);
  assign lim_hit   = (cnt_inc == {1'b0, lim});
  assign found_idx = wb_r + TOT_W'(p);
  assign np        = {1'b0, found_idx} + (TOT_W + 1)'(1);
  assign miss_add  = miss_r + MW'(endp - bo_r);
  assign exh_hit   = !hit && (miss_add >= MW'(tot));
  assign wrap_w    = (({1'b0, wb_r} + (TOT_W + 1)'(W)) >= {1'b0, tot});
  assign next_wa   = wrap_w ? '0 : wa_r + AW'(1);
  assign next_wb   = wrap_w ? '0 : wb_r + TOT_W'(W);

  // bitmap ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = src;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (cmd.set_bit) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata | ({{(W-1){1'b0}}, 1'b1} << bo_r[PW-1:0]);
    end else if (cmd.find_step) begin
      if (!hit) begin
        ram_we = 1'b1;
      end else if (lim_hit) begin
        ram_we    = 1'b1;
        ram_wdata = src & ~lowbit;
      end
    end
  end

  assign ram_re    = cmd.rd_cur || cmd.find_step;
  assign ram_raddr = cmd.find_step ? next_wa : wa_r;

  always_comb begin
    total_nxt     = total_r;
    limit_nxt     = limit_r;
    ptr_nxt       = ptr_r;
    null_nxt      = null_r;
    wa_nxt        = wa_r;
    out_valid_nxt = 1'b0;
    x_nxt         = x_r;
    prod_nxt      = prod_r;
    wb_nxt        = wb_r;
    bo_nxt        = bo_r;
    word_nxt      = word_r;
    use_rd_nxt    = use_rd_r;
    miss_nxt      = miss_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_ref_nxt  = pend_ref_r;
    exh_nxt       = exh_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOTAL: total_nxt = cfg_data[TOT_W-1:0];
        REG_LIMIT: limit_nxt = cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end

    if (cmd.clr_step) begin
      wa_nxt = wa_r + AW'(1);
    end

    if (cmd.acc_free) begin
      x_nxt = in_data.blk_num;
    end

    if (cmd.acc_scan) begin
      x_nxt      = start_idx;
      cnt_nxt    = '0;
      miss_nxt   = '0;
      pend_v_nxt = 1'b0;
      exh_nxt    = 1'b0;
    end

    if (cmd.acc_none) begin
      pend_v_nxt = 1'b0;
      exh_nxt    = 1'b0;
    end

    if (cmd.acc_exh) begin
      pend_v_nxt = 1'b0;
      exh_nxt    = 1'b1;
      ptr_nxt    = '0;
      null_nxt   = 1'b1;
    end

    if (cmd.div_mul) begin
      prod_nxt = {{RW{1'b0}}, x_r} * {{BLK_W{1'b0}}, RECIP_V};
    end

    if (cmd.div_fix) begin
      wa_nxt = AW'(q_fin);
      bo_nxt = BOW'(r_fin);
      wb_nxt = TOT_W'(x_r - r_fin);
    end

    if (cmd.rd_cur) begin
      use_rd_nxt = 1'b1;
    end

    if (cmd.find_step) begin
      if (hit) begin
        // hold back one beat so the final one can carry last
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{block_ref: pend_ref_r, ref_valid: 1'b1,
                            last: 1'b0, exhausted: 1'b0};
        end
        pend_v_nxt   = 1'b1;
        pend_ref_nxt = found_idx[BLK_W-1:0];
        word_nxt     = src & ~lowbit;
        use_rd_nxt   = 1'b0;
        bo_nxt       = BOW'(p) + BOW'(1);
        miss_nxt     = '0;
        cnt_nxt      = cnt_inc[LIM_W-1:0];
        if (lim_hit) begin
          exh_nxt  = 1'b0;
          null_nxt = 1'b0;
          ptr_nxt  = (np >= {1'b0, tot}) ? '0 : np[BLK_W-1:0];
        end
      end else begin
        miss_nxt = miss_add;
        if (exh_hit) begin
          exh_nxt  = 1'b1;
          ptr_nxt  = '0;
          null_nxt = 1'b1;
        end else begin
          wa_nxt = next_wa;
          wb_nxt = next_wb;
          bo_nxt = '0;
          // a total within one word wraps onto the same word: the prefetch is stale
          if (next_wa == wa_r) begin
            word_nxt   = src;
            use_rd_nxt = 1'b0;
          end else begin
            use_rd_nxt = 1'b1;
          end
        end
      end
    end

    if (cmd.emit_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{block_ref: pend_v_r ? pend_ref_r : '0, ref_valid: pend_v_r,
                        last: 1'b1, exhausted: exh_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= TOTAL_RST;
      limit_r     <= LIMIT_RST;
      ptr_r       <= '0;
      null_r      <= 1'b0;
      wa_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      limit_r     <= limit_nxt;
      ptr_r       <= ptr_nxt;
      null_r      <= null_nxt;
      wa_r        <= wa_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    prod_r     <= prod_nxt;
    wb_r       <= wb_nxt;
    bo_r       <= bo_nxt;
    word_r     <= word_nxt;
    use_rd_r   <= use_rd_nxt;
    miss_r     <= miss_nxt;
    cnt_r      <= cnt_nxt;
    pend_v_r   <= pend_v_nxt;
    pend_ref_r <= pend_ref_nxt;
    exh_r      <= exh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
